### hw/rtl/brt_pkg.sv
// Shared request and status codes for the breakpoint range table.
// Also holds the control group that moves between neighboring cells.
// Depends on nothing.
`default_nettype none

package brt_pkg;

   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERLAP = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic valid;
      logic found;
   } tok_ctl_type;

endpackage

`default_nettype wire

### hw/rtl/brt_cell.sv
// One cell of the range chain: holds one stored range and refines the search token.
// Depends on brt_pkg.
`default_nettype none

module brt_cell #(
   parameter int ENTRIES   = 16,
   parameter int ADDR_BITS = 32,
   parameter int SIZE_BITS = 16,
   parameter int IDX       = 0,
   localparam int CNT_W    = $clog2(ENTRIES + 1)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire        [CNT_W-1:0]       count,
   input  wire                          wr_en,
   input  wire        [ADDR_BITS-1:0]   wr_base,
   input  wire        [SIZE_BITS-1:0]   wr_size,
   input  wire        [ADDR_BITS:0]     wr_end,
   input  wire        [ADDR_BITS-1:0]   q_addr,
   input  wire        [ADDR_BITS:0]     q_end,
   input  wire                          q_nz,
   input  wire                          lower_vld,
   input  wire        [ADDR_BITS-1:0]   lower,
   input  brt_pkg::tok_ctl_type         tin_ctl,
   input  wire        [ADDR_BITS-1:0]   tin_base,
   input  wire        [SIZE_BITS-1:0]   tin_size,
   input  wire        [CNT_W-1:0]       tin_hits,
   output brt_pkg::tok_ctl_type         tout_ctl,
   output logic       [ADDR_BITS-1:0]   tout_base,
   output logic       [SIZE_BITS-1:0]   tout_size,
   output logic       [CNT_W-1:0]       tout_hits
);

   logic [ADDR_BITS-1:0] base_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic [ADDR_BITS:0]   end_ff;
   logic                 tvalid_ff;
   logic                 tfound_ff;
   logic                 live;
   logic                 ovl;
   logic                 cand;
   logic                 take;

   assign live = count > CNT_W'(IDX);
   assign ovl  = live && q_nz && (size_ff != '0) &&
                 ({1'b0, q_addr} < end_ff) && ({1'b0, base_ff} < q_end);
   assign cand = ovl && (!lower_vld || (base_ff > lower));
   assign take = cand && (!tin_ctl.found || (base_ff < tin_base));

   always_ff @(posedge clock) begin
      if (wr_en && (count == CNT_W'(IDX))) begin
         base_ff <= wr_base;
         size_ff <= wr_size;
         end_ff  <= wr_end;
      end
      if (reset) begin
         tvalid_ff <= 1'b0;
         tfound_ff <= 1'b0;
      end else begin
         tvalid_ff <= tin_ctl.valid;
         tfound_ff <= tin_ctl.found || take;
      end
      tout_base <= take ? base_ff : tin_base;
      tout_size <= take ? size_ff : tin_size;
      tout_hits <= tin_hits + CNT_W'(cand);
   end

   assign tout_ctl.valid = tvalid_ff;
   assign tout_ctl.found = tfound_ff;

endmodule

`default_nettype wire

### hw/rtl/breakpoint_range_table_top.sv
// Breakpoint range table: a chain of ENTRIES cells that a search token walks through.
// A request is registered, then the search token runs from a start register through the
// cell registers in order; the result at the chain's end is registered and then loaded
// into the result outputs, and a result stall delays that load. Each further query result
// starts a new pass once the previous one is loaded. One request is worked on at a time;
// the next is taken once the last result is queued.
// Synchronous reset empties the table; stored ranges are undefined until inserted.
// Depends on brt_pkg and brt_cell.
`default_nettype none

module breakpoint_range_table_top #(
   parameter int ENTRIES   = 16,
   parameter int ADDR_BITS = 32,
   parameter int SIZE_BITS = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire        [brt_pkg::KIND_W-1:0]  req_kind,
   input  wire        [ADDR_BITS-1:0]        req_addr,
   input  wire        [SIZE_BITS-1:0]        req_len,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic                              rsp_found,
   output logic       [ADDR_BITS-1:0]        rsp_range_base,
   output logic       [SIZE_BITS-1:0]        rsp_range_size,
   output logic       [brt_pkg::STATUS_W-1:0] rsp_status,
   output logic                              rsp_last
);

   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type                       state_ff;
   logic [brt_pkg::KIND_W-1:0]      kind_ff;
   logic [ADDR_BITS-1:0]            addr_ff;
   logic [SIZE_BITS-1:0]            len_ff;
   logic [ADDR_BITS:0]              end_ff;
   logic                            qnz_ff;
   logic                            lower_vld_ff;
   logic [ADDR_BITS-1:0]            lower_ff;
   logic [CNT_W-1:0]                cnt_ff;
   logic                            start_ff;
   logic                            cont_ff;
   logic                            res_found_ff;
   logic [ADDR_BITS-1:0]            res_base_ff;
   logic [SIZE_BITS-1:0]            res_size_ff;
   logic [brt_pkg::STATUS_W-1:0]    res_status_ff;
   logic                            res_last_ff;
   logic                            rsp_valid_ff;

   brt_pkg::tok_ctl_type            tok_ctl  [0:ENTRIES];
   logic [ADDR_BITS-1:0]            tok_base [0:ENTRIES];
   logic [SIZE_BITS-1:0]            tok_size [0:ENTRIES];
   logic [CNT_W-1:0]                tok_hits [0:ENTRIES];
   logic [ENTRIES-1:0]              tok_live;

   logic                            req_beat;
   logic                            rsp_beat;
   logic                            tail;
   logic                            wr_en;
   logic                            known_kind;
   logic                            load_rsp;
   logic                            launch;
   logic                            more_hits;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_beat   = req_valid && req_ready;
   assign rsp_beat   = rsp_valid_ff && rsp_ready;
   assign tail       = tok_ctl[ENTRIES].valid;
   assign known_kind = (req_kind == brt_pkg::KIND_LOOKUP) ||
                       (req_kind == brt_pkg::KIND_QUERY) ||
                       (req_kind == brt_pkg::KIND_INSERT);
   assign wr_en      = (state_ff == ST_SCAN) && tail &&
                       (kind_ff == brt_pkg::KIND_INSERT) &&
                       (tok_hits[ENTRIES] == '0) && (cnt_ff != CNT_W'(ENTRIES));
   assign load_rsp   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign launch     = (req_beat && known_kind) || (load_rsp && cont_ff);
   assign more_hits  = tok_ctl[ENTRIES].found && (kind_ff == brt_pkg::KIND_QUERY) &&
                       (tok_hits[ENTRIES] > CNT_W'(1));

   assign tok_ctl[0].valid = start_ff;
   assign tok_ctl[0].found = 1'b0;
   assign tok_base[0]      = '0;
   assign tok_size[0]      = '0;
   assign tok_hits[0]      = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      brt_cell #(
         .ENTRIES   (ENTRIES),
         .ADDR_BITS (ADDR_BITS),
         .SIZE_BITS (SIZE_BITS),
         .IDX       (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .count     (cnt_ff),
         .wr_en     (wr_en),
         .wr_base   (addr_ff),
         .wr_size   (len_ff),
         .wr_end    (end_ff),
         .q_addr    (addr_ff),
         .q_end     (end_ff),
         .q_nz      (qnz_ff),
         .lower_vld (lower_vld_ff),
         .lower     (lower_ff),
         .tin_ctl   (tok_ctl[g]),
         .tin_base  (tok_base[g]),
         .tin_size  (tok_size[g]),
         .tin_hits  (tok_hits[g]),
         .tout_ctl  (tok_ctl[g+1]),
         .tout_base (tok_base[g+1]),
         .tout_size (tok_size[g+1]),
         .tout_hits (tok_hits[g+1])
      );
      assign tok_live[g] = tok_ctl[g+1].valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         start_ff     <= 1'b0;
         cont_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lower_vld_ff <= 1'b0;
      end else begin
         start_ff <= launch;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_beat) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  kind_ff      <= req_kind;
                  addr_ff      <= req_addr;
                  len_ff       <= req_len;
                  lower_vld_ff <= 1'b0;
                  cont_ff      <= 1'b0;
                  if (req_kind == brt_pkg::KIND_LOOKUP) begin
                     end_ff <= {1'b0, req_addr} + (ADDR_BITS+1)'(1);
                     qnz_ff <= 1'b1;
                  end else begin
                     end_ff <= {1'b0, req_addr} + (ADDR_BITS+1)'(req_len);
                     qnz_ff <= (req_len != '0);
                  end
                  if (known_kind) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     res_found_ff  <= 1'b0;
                     res_base_ff   <= '0;
                     res_size_ff   <= '0;
                     res_status_ff <= brt_pkg::STATUS_OK;
                     res_last_ff   <= 1'b1;
                     state_ff      <= ST_EMIT;
                  end
               end
            end
            ST_SCAN: begin
               if (tail) begin
                  if (kind_ff == brt_pkg::KIND_INSERT) begin
                     res_found_ff <= 1'b0;
                     res_base_ff  <= '0;
                     res_size_ff  <= '0;
                     res_last_ff  <= 1'b1;
                     if (tok_hits[ENTRIES] != '0) begin
                        res_status_ff <= brt_pkg::STATUS_OVERLAP;
                     end else if (cnt_ff == CNT_W'(ENTRIES)) begin
                        res_status_ff <= brt_pkg::STATUS_FULL;
                     end else begin
                        res_status_ff <= brt_pkg::STATUS_OK;
                        cnt_ff        <= cnt_ff + CNT_W'(1);
                     end
                  end else begin
                     res_found_ff  <= tok_ctl[ENTRIES].found;
                     res_base_ff   <= tok_ctl[ENTRIES].found ? tok_base[ENTRIES] : '0;
                     res_size_ff   <= tok_ctl[ENTRIES].found ? tok_size[ENTRIES] : '0;
                     res_status_ff <= brt_pkg::STATUS_OK;
                     res_last_ff   <= !more_hits;
                     if (more_hits) begin
                        cont_ff      <= 1'b1;
                        lower_vld_ff <= 1'b1;
                        lower_ff     <= tok_base[ENTRIES];
                     end
                  end
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (load_rsp) begin
                  rsp_found      <= res_found_ff;
                  rsp_range_base <= res_base_ff;
                  rsp_range_size <= res_size_ff;
                  rsp_status     <= res_status_ff;
                  rsp_last       <= res_last_ff;
                  if (cont_ff) begin
                     cont_ff  <= 1'b0;
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail |-> (state_ff == ST_SCAN))
      else $error("search token left the chain outside a scan");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(ENTRIES))
      else $error("entry count exceeds table depth");

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_live))
      else $error("more than one search token in the chain");

   a_write_grows: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("insert did not advance the entry count");

   a_cont_not_last: assert property (@(posedge clock) disable iff (reset)
      (cont_ff && (state_ff == ST_EMIT)) |-> (!res_last_ff && res_found_ff))
      else $error("query continues after a final or empty result");

endmodule

`default_nettype wire

### dv/breakpoint_range_table_checker.sv
// Checker for the breakpoint range table: watches the request and result channels,
// keeps its own copy of the range table and compares every result beat with the prediction.
// Depends on brt_pkg.
`timescale 1ns / 100ps

module breakpoint_range_table_checker #(
   parameter int ENTRIES   = 16,
   parameter int ADDR_BITS = 32,
   parameter int SIZE_BITS = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_ready,
   input  wire        [brt_pkg::KIND_W-1:0]   req_kind,
   input  wire        [ADDR_BITS-1:0]         req_addr,
   input  wire        [SIZE_BITS-1:0]         req_len,
   input  wire                                rsp_valid,
   input  wire                                rsp_ready,
   input  wire                                rsp_found,
   input  wire        [ADDR_BITS-1:0]         rsp_range_base,
   input  wire        [SIZE_BITS-1:0]         rsp_range_size,
   input  wire        [brt_pkg::STATUS_W-1:0] rsp_status,
   input  wire                                rsp_last,
   output int                                 mismatch_count,
   output int                                 beats_due
);

   typedef struct {
      logic                         found;
      logic [ADDR_BITS-1:0]         base;
      logic [SIZE_BITS-1:0]         size;
      logic [brt_pkg::STATUS_W-1:0] status;
      logic                         last;
   } rsp_beat_type;

   rsp_beat_type         rsp_due[$];
   rsp_beat_type         head;
   logic [ADDR_BITS-1:0] bp_base[ENTRIES];
   logic [SIZE_BITS-1:0] bp_size[ENTRIES];
   int                   bp_count = 0;

   // Exact overlap of [a, a+la) and [b, b+lb); the difference never wraps.
   function automatic bit spans_meet(logic [ADDR_BITS-1:0] a, logic [SIZE_BITS-1:0] la,
                                     logic [ADDR_BITS-1:0] b, logic [SIZE_BITS-1:0] lb);
      logic [ADDR_BITS:0] gap;
      if (la == 0 || lb == 0) return 1'b0;
      if (a >= b) begin
         gap = {1'b0, a} - {1'b0, b};
         return gap < lb;
      end
      gap = {1'b0, b} - {1'b0, a};
      return gap < la;
   endfunction

   function automatic void queue_beat(logic found, logic [ADDR_BITS-1:0] base,
                                      logic [SIZE_BITS-1:0] size,
                                      logic [brt_pkg::STATUS_W-1:0] status, logic last);
      rsp_beat_type beat;
      beat.found = found;
      beat.base = base;
      beat.size = size;
      beat.status = status;
      beat.last = last;
      rsp_due.insert(rsp_due.size(), beat);
   endfunction

   function automatic void apply_request(logic [brt_pkg::KIND_W-1:0] kind,
                                         logic [ADDR_BITS-1:0] addr,
                                         logic [SIZE_BITS-1:0] len);
      int hit_list[$];
      int pos;
      case (kind)
         brt_pkg::KIND_LOOKUP: begin
            for (int i = 0; i < bp_count; i++) begin
               if (spans_meet(addr, SIZE_BITS'(1), bp_base[i], bp_size[i])) begin
                  queue_beat(1'b1, bp_base[i], bp_size[i], brt_pkg::STATUS_OK, 1'b1);
                  return;
               end
            end
            queue_beat(1'b0, '0, '0, brt_pkg::STATUS_OK, 1'b1);
         end
         brt_pkg::KIND_QUERY: begin
            for (int i = 0; i < bp_count; i++) begin
               if (spans_meet(addr, len, bp_base[i], bp_size[i])) begin
                  pos = hit_list.size();
                  while (pos > 0 && bp_base[hit_list[pos-1]] > bp_base[i]) pos--;
                  hit_list.insert(pos, i);
               end
            end
            if (hit_list.size() == 0) begin
               queue_beat(1'b0, '0, '0, brt_pkg::STATUS_OK, 1'b1);
            end else begin
               foreach (hit_list[j]) begin
                  queue_beat(1'b1, bp_base[hit_list[j]], bp_size[hit_list[j]],
                             brt_pkg::STATUS_OK, j == hit_list.size() - 1);
               end
            end
         end
         brt_pkg::KIND_INSERT: begin
            for (int i = 0; i < bp_count; i++) begin
               if (spans_meet(addr, len, bp_base[i], bp_size[i])) begin
                  queue_beat(1'b0, '0, '0, brt_pkg::STATUS_OVERLAP, 1'b1);
                  return;
               end
            end
            if (bp_count >= ENTRIES) begin
               queue_beat(1'b0, '0, '0, brt_pkg::STATUS_FULL, 1'b1);
            end else begin
               bp_base[bp_count] = addr;
               bp_size[bp_count] = len;
               bp_count++;
               queue_beat(1'b0, '0, '0, brt_pkg::STATUS_OK, 1'b1);
            end
         end
         default: begin
            queue_beat(1'b0, '0, '0, brt_pkg::STATUS_OK, 1'b1);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_due.delete();
         bp_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result beat with nothing expected: ", $realtime,
                           "found=%0b base=%h size=%h status=%0d last=%0b",
                           rsp_found, rsp_range_base, rsp_range_size, rsp_status,
                           rsp_last);
            end else begin
               head = rsp_due.pop_front();
               if (head.found !== rsp_found || head.base !== rsp_range_base ||
                   head.size !== rsp_range_size || head.status !== rsp_status ||
                   head.last !== rsp_last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: expected found=%0b base=%h size=%h status=%0d last=%0b, ",
                              $realtime, head.found, head.base, head.size, head.status,
                              head.last,
                              "got found=%0b base=%h size=%h status=%0d last=%0b",
                              rsp_found, rsp_range_base, rsp_range_size,
                              rsp_status, rsp_last);
               end
            end
         end
         if (req_valid && req_ready) apply_request(req_kind, req_addr, req_len);
      end
      beats_due = rsp_due.size();
   end

endmodule

### dv/breakpoint_range_table_top_test.sv
// Top of the breakpoint range table testbench: clock, reset, request and result stimulus
// with random gaps, and the final verdict. Depends on brt_pkg, breakpoint_range_table_top
// and breakpoint_range_table_checker.
`timescale 1ns / 100ps

module breakpoint_range_table_top_test;

   localparam int ENTRIES   = 16;
   localparam int ADDR_BITS = 32;
   localparam int SIZE_BITS = 16;

   localparam logic [brt_pkg::KIND_W-1:0] KIND_UNKNOWN = 2'd3;
   localparam logic [ADDR_BITS-1:0]       WINDOW_BASE  = 32'h4000_0000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic [brt_pkg::KIND_W-1:0]   req_kind = brt_pkg::KIND_LOOKUP;
   logic [ADDR_BITS-1:0]         req_addr = '0;
   logic [SIZE_BITS-1:0]         req_len = '0;
   logic                         rsp_ready = 1'b0;
   wire                          req_ready;
   wire                          rsp_valid;
   wire                          rsp_found;
   wire  [ADDR_BITS-1:0]         rsp_range_base;
   wire  [SIZE_BITS-1:0]         rsp_range_size;
   wire  [brt_pkg::STATUS_W-1:0] rsp_status;
   wire                          rsp_last;
   int                           mismatch_count;
   int                           beats_due;
   bit                           steady = 1'b0;
   int                           rsp_hold = 0;
   int                           stall_draw;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   breakpoint_range_table_top #(
      .ENTRIES  (ENTRIES),
      .ADDR_BITS(ADDR_BITS),
      .SIZE_BITS(SIZE_BITS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_addr      (req_addr),
      .req_len       (req_len),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_found     (rsp_found),
      .rsp_range_base(rsp_range_base),
      .rsp_range_size(rsp_range_size),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   breakpoint_range_table_checker #(
      .ENTRIES  (ENTRIES),
      .ADDR_BITS(ADDR_BITS),
      .SIZE_BITS(SIZE_BITS)
   ) table_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_addr      (req_addr),
      .req_len       (req_len),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_found     (rsp_found),
      .rsp_range_base(rsp_range_base),
      .rsp_range_size(rsp_range_size),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last),
      .mismatch_count(mismatch_count),
      .beats_due     (beats_due)
   );

   // After each accepted result beat the receiver may drop ready for a randomly drawn stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (!rsp_ready) begin
         rsp_ready <= 1'b1;
      end else if (rsp_valid) begin
         stall_draw = steady ? 0 : $urandom_range(0, 4);
         if (stall_draw > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold <= stall_draw - 1;
         end
      end
   end

   task automatic issue(input logic [brt_pkg::KIND_W-1:0] kind, input logic [ADDR_BITS-1:0] addr,
                        input logic [SIZE_BITS-1:0] len);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_addr <= addr;
      req_len <= len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin
      logic [brt_pkg::KIND_W-1:0] kind;
      logic [ADDR_BITS-1:0]       addr;
      logic [SIZE_BITS-1:0]       len;
      int                         kind_draw;
      int                         addr_draw;
      int                         len_draw;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      issue(brt_pkg::KIND_LOOKUP, 32'h0000_0000, 16'h0000);
      issue(brt_pkg::KIND_QUERY,  32'h0000_0000, 16'hFFFF);
      issue(brt_pkg::KIND_INSERT, 32'hFFFF_FF00, 16'hFFFF);
      issue(brt_pkg::KIND_LOOKUP, 32'h0000_0000, 16'hFFFF);
      issue(brt_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
      issue(brt_pkg::KIND_QUERY,  32'hFFFF_FFFF, 16'hFFFF);
      issue(brt_pkg::KIND_INSERT, 32'h0000_0200, 16'h0010);
      issue(brt_pkg::KIND_INSERT, 32'h0000_0100, 16'h0000);
      issue(brt_pkg::KIND_LOOKUP, 32'h0000_0100, 16'h0000);
      issue(brt_pkg::KIND_INSERT, 32'h0000_0100, 16'h0010);
      issue(brt_pkg::KIND_INSERT, 32'h0000_010F, 16'h0004);
      issue(brt_pkg::KIND_INSERT, 32'h0000_0110, 16'h00F0);
      issue(brt_pkg::KIND_INSERT, 32'h0000_0000, 16'h0001);
      issue(brt_pkg::KIND_QUERY,  32'h0000_0000, 16'hFFFF);
      issue(brt_pkg::KIND_QUERY,  32'h0000_0150, 16'h0000);
      issue(brt_pkg::KIND_LOOKUP, 32'h0000_01FF, 16'h0000);
      issue(brt_pkg::KIND_LOOKUP, 32'h0000_0200, 16'h0000);
      issue(brt_pkg::KIND_LOOKUP, 32'h0000_0210, 16'h0000);
      issue(KIND_UNKNOWN,         32'hFFFF_FFFF, 16'hFFFF);
      issue(brt_pkg::KIND_INSERT, 32'hFFFF_0000, 16'hFFFF);

      // Most addresses fall in one small window so that ranges collide and queries return
      // several beats; the rest spread over the whole space and its top end.
      for (int n = 0; n < 210; n++) begin
         if (n % 35 == 0) steady = ($urandom_range(0, 2) == 0);
         kind_draw = $urandom_range(0, 99);
         if (kind_draw < 35) kind = brt_pkg::KIND_LOOKUP;
         else if (kind_draw < 65) kind = brt_pkg::KIND_QUERY;
         else if (kind_draw < 95) kind = brt_pkg::KIND_INSERT;
         else kind = KIND_UNKNOWN;
         addr_draw = $urandom_range(0, 99);
         if (addr_draw < 65) addr = WINDOW_BASE + $urandom_range(0, 32'h0001_FFFF);
         else if (addr_draw < 85) addr = $urandom;
         else addr = 32'hFFFF_0000 + $urandom_range(0, 32'h0000_FFFF);
         len_draw = $urandom_range(0, 99);
         if (len_draw < 10) len = '0;
         else if (len_draw < 25) len = 16'hFFFF;
         else if (kind == brt_pkg::KIND_INSERT) len = SIZE_BITS'($urandom_range(1, 16'h1FFF));
         else len = SIZE_BITS'($urandom);
         issue(kind, addr, len);
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      @(posedge clock);
      while (beats_due != 0) @(posedge clock);
      repeat (2 * ENTRIES + 8) @(posedge clock);
      if (mismatch_count == 0 && beats_due == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
